[hw/rtl/pkcf_pkg.sv]
// Shared constants for the per-key chatter filter.
package pkcf_pkg;

  localparam int MAX_SLOTS = 8;
  localparam int DEF_NUM_SLOTS = 8;
  localparam int CODE_W = 8;
  localparam int TIME_W = 52;
  localparam int THR_W = 24;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [CODE_W-1:0] UNUSED_SLOT = 8'hFF;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 24'd50000;
  localparam logic [CFG_DATA_W-1:0] WATCHED_RST = 64'h392E311F1312110E;

  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic signed [31:0] KEY_PRESS = 32'sd1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WATCHED = 8'd1;

endpackage

[hw/rtl/per_key_chatter_filter.sv]
// Top level of the per-key chatter filter: input stage, press check, output register.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | in_ev_type, in_ev_code, in_ev_value, in_time_*
//  out     | out_valid / out_ready | out_type, out_code, out_value, out_sec, out_usec
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle unless the output stalls. Timestamp multiply into the input stage,
// then slot compare and store update against the per-slot press times into the output.
// Synchronous active-low reset clears the press times, so every slot reads never pressed.
// A stalled output holds its request; the input stage still retires dropped presses.
// cfg_ready is always high.
module per_key_chatter_filter
  import pkcf_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_ev_type,
  input  logic [15:0]           in_ev_code,
  input  logic signed [31:0]    in_ev_value,
  input  logic [31:0]           in_time_sec,
  input  logic [19:0]           in_time_usec,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_type,
  output logic [15:0]           out_code,
  output logic signed [31:0]    out_value,
  output logic [31:0]           out_sec,
  output logic [19:0]           out_usec,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WC_W = CODE_W * NUM_SLOTS;

  logic [THR_W-1:0] threshold_r;
  logic [WC_W-1:0]  watched_r;

  logic               s1_valid_r;
  logic [15:0]        s1_type_r;
  logic [15:0]        s1_code_r;
  logic signed [31:0] s1_value_r;
  logic [31:0]        s1_sec_r;
  logic [19:0]        s1_usec_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [TIME_W-1:0]  now_nxt;

  logic [TIME_W-1:0] last_r [NUM_SLOTS];

  logic               out_valid_r;
  logic [15:0]        out_type_r;
  logic [15:0]        out_code_r;
  logic signed [31:0] out_value_r;
  logic [31:0]        out_sec_r;
  logic [19:0]        out_usec_r;

  logic [NUM_SLOTS-1:0] hit_oh;
  logic [TIME_W-1:0]    last_rd;
  logic [TIME_W:0]      diff;
  logic                 is_press;
  logic                 hit;
  logic                 drop;
  logic                 upd;
  logic                 s2_free;
  logic                 s1_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      watched_r   <= WATCHED_RST[WC_W-1:0];
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        REG_WATCHED:   watched_r   <= cfg_data[WC_W-1:0];
        default: ;
      endcase
    end
  end

  assign now_nxt = {{(TIME_W - 32){1'b0}}, in_time_sec} * {{(TIME_W - 20){1'b0}}, USEC_PER_SEC}
                 + {{(TIME_W - 20){1'b0}}, in_time_usec};

  assign s2_free  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type_r  <= in_ev_type;
      s1_code_r  <= in_ev_code;
      s1_value_r <= in_ev_value;
      s1_sec_r   <= in_time_sec;
      s1_usec_r  <= in_time_usec;
      s1_now_r   <= now_nxt;
    end
  end

  pkcf_slot_match #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_match (
    .watched (watched_r),
    .code    (s1_code_r),
    .hit_oh  (hit_oh)
  );

  always_comb begin
    last_rd = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      last_rd = last_rd | (last_r[i] & {TIME_W{hit_oh[i]}});
    end
  end

  assign is_press = (s1_type_r == EV_KEY) && (s1_value_r == KEY_PRESS);
  assign hit      = |hit_oh;
  assign diff     = {1'b0, s1_now_r} - {1'b0, last_rd};
  assign drop     = is_press && hit && (last_rd != '0) &&
                    ($signed(diff) < $signed({(TIME_W + 1 - THR_W)'(0), threshold_r}));
  assign upd      = s1_adv && is_press && hit && !drop;
  assign s1_adv   = s1_valid_r && (drop || s2_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        last_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (upd && hit_oh[i]) begin
          last_r[i] <= s1_now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && !drop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !drop) begin
      out_type_r  <= s1_type_r;
      out_code_r  <= s1_code_r;
      out_value_r <= s1_value_r;
      out_sec_r   <= s1_sec_r;
      out_usec_r  <= s1_usec_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_type  = out_type_r;
  assign out_code  = out_code_r;
  assign out_value = out_value_r;
  assign out_sec   = out_sec_r;
  assign out_usec  = out_usec_r;

`ifndef SYNTHESIS
  a_fwd_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !drop) |=> out_valid_r)
    else $error("forwarded request did not reach the output register");

  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(hit_oh))
    else $error("more than one slot selected");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_now_r)))
    else $error("input stage lost a stalled request");

  a_drop_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && drop) |-> (last_rd != '0 && s1_adv))
    else $error("drop without a stored press or without retiring");
`endif

endmodule

[hw/rtl/pkcf_slot_match.sv]
// Watched-code match: one-hot select of the highest matching slot.
module pkcf_slot_match
  import pkcf_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic [CODE_W*NUM_SLOTS-1:0] watched,
  input  logic [15:0]                 code,
  output logic [NUM_SLOTS-1:0]        hit_oh
);

  logic [NUM_SLOTS-1:0] match;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = (watched[CODE_W*i +: CODE_W] != UNUSED_SLOT) &&
                 (code[15:CODE_W] == '0) &&
                 (code[CODE_W-1:0] == watched[CODE_W*i +: CODE_W]);
    end
  end

  // highest-numbered match wins
  always_comb begin
    hit_oh = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (match[i]) begin
        hit_oh = '0;
        hit_oh[i] = 1'b1;
      end
    end
  end

endmodule
